@@ rtl/b64d_pkg.sv @@
// b64d_pkg: shared types, constants and the character map of the strict base64 decoder
// no dependencies
package b64d_pkg;

  localparam int unsigned MAX_VALUE_BYTES = 65535;
  localparam int unsigned COUNT_W         = 17;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);

  localparam logic [COUNT_W:0] MAX_BYTES_L = (COUNT_W + 1)'(MAX_VALUE_BYTES);

  // place of a character within its group of four
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_FOURTH = 2'd3;

  localparam logic [7:0] PAD_CHAR   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;

  // one finished group (or the closing mark) handed from front to back
  typedef struct packed {
    logic [23:0] word;
    logic [1:0]  cnt;       // bytes to emit, 0 only for a bare closing result
    logic        last;
    logic        status;
  } group_desc_t;

  // bit 6 set: not an alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] ch);
    logic [6:0] r;
    begin
      r = 7'h40;
      if (ch >= 8'h41 && ch <= 8'h5A) r = 7'(ch - 8'h41);
      else if (ch >= 8'h61 && ch <= 8'h7A) r = 7'(ch - 8'h61 + 8'd26);
      else if (ch >= 8'h30 && ch <= 8'h39) r = 7'(ch - 8'h30 + 8'd52);
      else if (ch == CHAR_PLUS) r = 7'd62;
      else if (ch == CHAR_SLASH) r = 7'd63;
      return r;
    end
  endfunction

endpackage

@@ rtl/b64d_if.sv @@
// b64d_in_if, b64d_out_if: valid/ready channels of the strict base64 decoder
// depends on nothing
interface b64d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source(output valid, char_code, is_last, input ready);
  modport sink(input valid, char_code, is_last, output ready);
endinterface

interface b64d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_value;
  logic       status;

  modport source(output valid, data_byte, has_byte, end_of_value, status, input ready);
  modport sink(input valid, data_byte, has_byte, end_of_value, status, output ready);
endinterface

@@ rtl/strict_base64_decoder_unit.sv @@
// strict_base64_decoder_unit: top level of the strict streaming base64 decoder
// depends on b64d_pkg, b64d_if, b64d_front, b64d_queue, b64d_back
//
// Usage: one character of a standard-alphabet base64 string per in_ch item,
// with is_last set on the string's final character. Each complete group of four
// gives one to three out_ch items carrying a decoded byte. The last character
// always ends with a closing item (end_of_value set, status 0 accepted or 1
// rejected) riding on the last byte, or on its own with has_byte 0.
// Bytes emitted before a reject stand; the consumer drops them on status 1.
// Throughput: one character per cycle sustained while the queue has room. The
// front checks a character and updates the group state in the cycle it is
// accepted; finished groups wait in a four-entry queue, and the back hands out
// one result per cycle while the receiver is ready, through its output register,
// so a group of three bytes gives three results.
// Reset (synchronous, rst_n low) clears the group state, queue and output stage.
// A stalled receiver holds the output register; the queue absorbs finished groups
// and in_ch.ready drops only when the queue is full.
module strict_base64_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  b64d_in_if.sink     in_ch,
  b64d_out_if.source  out_ch
);
  import b64d_pkg::*;

  logic        q_ready;
  logic        push;
  group_desc_t push_desc;
  logic        pop;
  logic        head_valid;
  group_desc_t head_desc;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .q_ready   (q_ready),
    .push      (push),
    .push_desc (push_desc)
  );

  b64d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .q_ready    (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/b64d_front.sv @@
// b64d_front: accepts characters, checks them and collects groups of four
// depends on b64d_pkg and b64d_in_if
module b64d_front (
  input  logic                  clk,
  input  logic                  rst_n,
  b64d_in_if.sink               in_ch,
  input  logic                  q_ready,
  output logic                  push,
  output b64d_pkg::group_desc_t push_desc
);
  import b64d_pkg::*;

  logic [1:0]         pos_r, pos_nxt;
  logic [17:0]        held_r, held_nxt;
  logic               pad3_r, pad3_nxt;
  logic               err_r, err_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic               accept;
  logic [6:0]         sx;
  logic               bad_ch;
  logic [5:0]         s;
  logic               pad;
  logic               grp_bad;
  logic               emit;
  logic [1:0]         k;
  logic [COUNT_W:0]   sum;

  assign in_ch.ready = q_ready;
  assign accept      = in_ch.valid && q_ready;

  always_comb begin
    sx       = sextet_of(in_ch.char_code);
    bad_ch   = sx[6];
    s        = bad_ch ? 6'd0 : sx[5:0];
    pad      = (in_ch.char_code == PAD_CHAR);
    pos_nxt  = pos_r;
    held_nxt = held_r;
    pad3_nxt = pad3_r;
    err_nxt  = err_r;
    count_nxt = count_r;
    grp_bad  = 1'b0;
    emit     = 1'b0;
    k        = pad3_r ? 2'd1 : (pad ? 2'd2 : 2'd3);
    sum      = {1'b0, count_r} + (COUNT_W + 1)'(k);
    push_desc.word   = {held_r, (pad || bad_ch) ? 6'd0 : s};
    push_desc.cnt    = 2'd0;
    push_desc.last   = 1'b0;
    push_desc.status = 1'b0;
    if (accept) begin
      unique case (pos_r) inside
        POS_FIRST, POS_SECOND: begin
          if (bad_ch) err_nxt = 1'b1;
          held_nxt = (pos_r == POS_FIRST) ? {12'd0, s} : {held_r[11:0], s};
        end
        POS_THIRD: begin
          if (pad) pad3_nxt = 1'b1;
          else if (bad_ch) err_nxt = 1'b1;
          held_nxt = {held_r[11:0], pad ? 6'd0 : s};
        end
        default: begin
          // fourth character closes the group
          grp_bad = (!pad && bad_ch) ||
                    (!in_ch.is_last && (pad3_r || pad)) ||
                    (pad3_r && !pad) ||
                    (pad3_r && held_r[9:6] != 4'd0) ||
                    (!pad3_r && pad && held_r[1:0] != 2'd0);
          err_nxt = err_r || grp_bad;
          if (!err_nxt) begin
            if (sum > MAX_BYTES_L) begin
              err_nxt = 1'b1;
            end else begin
              emit      = 1'b1;
              count_nxt = sum[COUNT_W-1:0];
            end
          end
          pad3_nxt = 1'b0;
        end
      endcase
      pos_nxt = pos_r + 2'd1;
      if (emit) push_desc.cnt = k;
      if (in_ch.is_last) begin
        push_desc.last   = 1'b1;
        push_desc.status = err_nxt || (pos_r != POS_FOURTH);
        pos_nxt   = POS_FIRST;
        held_nxt  = 18'd0;
        pad3_nxt  = 1'b0;
        err_nxt   = 1'b0;
        count_nxt = '0;
      end
    end
  end

  assign push = accept && (emit || in_ch.is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_FIRST;
      held_r  <= 18'd0;
      pad3_r  <= 1'b0;
      err_r   <= 1'b0;
      count_r <= '0;
    end else begin
      pos_r   <= pos_nxt;
      held_r  <= held_nxt;
      pad3_r  <= pad3_nxt;
      err_r   <= err_nxt;
      count_r <= count_nxt;
    end
  end

  a_pad3_only_mid_group: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_FIRST || pos_r == POS_SECOND || pos_r == POS_THIRD) |-> !pad3_r)
    else $error("third-place pad flag outlived its group");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, count_r} <= MAX_BYTES_L)
    else $error("byte count beyond value size limit");

endmodule

@@ rtl/b64d_queue.sv @@
// b64d_queue: short queue of finished groups between front and back
// depends on b64d_pkg
module b64d_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64d_pkg::group_desc_t push_desc,
  output logic                  q_ready,
  input  logic                  pop,
  output logic                  head_valid,
  output b64d_pkg::group_desc_t head_desc
);
  import b64d_pkg::*;

  group_desc_t       mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign q_ready    = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_desc  = mem_r[rptr_r];
  assign do_push    = push && q_ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wptr_nxt = do_push ? QPTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = do_pop ? QPTR_W'(rptr_r + 1'b1) : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    else if (!do_push && do_pop) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_desc;
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("group pushed into full queue");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");

endmodule

@@ rtl/b64d_back.sv @@
// b64d_back: splits queued groups into byte results behind an output register
// depends on b64d_pkg and b64d_out_if
module b64d_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  head_valid,
  input  b64d_pkg::group_desc_t head_desc,
  output logic                  pop,
  b64d_out_if.source            out_ch
);
  import b64d_pkg::*;

  logic       ovalid_r, ovalid_nxt;
  logic [7:0] data_r, data_nxt;
  logic       has_r, has_nxt;
  logic       end_r, end_nxt;
  logic       stat_r, stat_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       load;
  logic       final_res;
  logic [7:0] sel_byte;

  assign out_ch.valid        = ovalid_r;
  assign out_ch.data_byte    = data_r;
  assign out_ch.has_byte     = has_r;
  assign out_ch.end_of_value = end_r;
  assign out_ch.status       = stat_r;

  always_comb begin
    load = head_valid && (!ovalid_r || out_ch.ready);
    // a group with no bytes still gives one closing result
    final_res = (head_desc.cnt == 2'd0) || (idx_r == head_desc.cnt - 2'd1);
    case (idx_r)
      2'd0:    sel_byte = head_desc.word[23:16];
      2'd1:    sel_byte = head_desc.word[15:8];
      default: sel_byte = head_desc.word[7:0];
    endcase
    ovalid_nxt = ovalid_r;
    data_nxt   = data_r;
    has_nxt    = has_r;
    end_nxt    = end_r;
    stat_nxt   = stat_r;
    idx_nxt    = idx_r;
    if (ovalid_r && out_ch.ready) ovalid_nxt = 1'b0;
    if (load) begin
      ovalid_nxt = 1'b1;
      has_nxt    = (head_desc.cnt != 2'd0);
      data_nxt   = has_nxt ? sel_byte : 8'd0;
      end_nxt    = head_desc.last && final_res;
      stat_nxt   = end_nxt && head_desc.status;
      idx_nxt    = final_res ? 2'd0 : idx_r + 2'd1;
    end
  end

  assign pop = load && final_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    has_r  <= has_nxt;
    end_r  <= end_nxt;
    stat_r <= stat_nxt;
  end

  a_bare_result_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !has_r) |-> end_r)
    else $error("result without byte that does not close the string");

  a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !end_r) |-> !stat_r)
    else $error("reject status on a result that is not the closing one");

endmodule
